### rtl/bfba_pkg.sv
package bfba_pkg;

	localparam int MAX_BLOCKS_DEF = 1024;
	localparam int CNT_W = 11;
	localparam int BLK_W = 32;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_MARK  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [BLK_W-1:0] first_blk;
		logic [CNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] alloc_start;
		logic [CNT_W-1:0] largest_run;
		logic [CNT_W-1:0] free_blocks;
	} rsp_t;

endpackage

### rtl/best_fit_block_bitmap_allocator.sv
// Best-fit allocator over a used/free bitmap of erase blocks.
// Input channel in_valid/in_ready carries one command transaction (allocate,
// free run, mark run, clear map); output channel out_valid/out_ready returns
// one result transaction per command with status, allocation start, largest
// free run and free block count. Configuration writes (cfg_index 0 base
// block, 1 block count) are taken at any time; cfg_ready is always high.
// The bitmap sits in a single-port memory of 32-bit words (8-bit words for
// maps below 32 blocks), with a registered read. Each command walks the
// words: a word is fetched (S_SRD, S_SLD) and then examined 8 bits at a
// time in S_SCH. A statistics scan covers the region blocks (at least one
// word); an allocate runs a best-fit scan, a write pass over the touched
// words, then the statistics scan; free/mark run a write pass then the
// scan; clear sweeps all words then scans. A rejected command, or a
// free/mark of zero blocks, skips the write pass. Commands are handled
// one at a time. After reset a clearing pass zeroes every memory word
// while in_ready stays low. The finished result is held in an output
// register; a new command can be accepted while it waits, but the next
// result is held back until out_ready takes the previous one.
module best_fit_block_bitmap_allocator #(
	parameter int MAX_BLOCKS = bfba_pkg::MAX_BLOCKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bfba_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bfba_pkg::rsp_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data
);
	import bfba_pkg::*;

	localparam int WW    = (MAX_BLOCKS >= 32) ? 32 : 8;
	localparam int LWW   = $clog2(WW);
	localparam int CH    = 8;
	localparam int DEPTH = (MAX_BLOCKS + WW - 1) / WW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(DEPTH * WW + 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SRD, S_SLD, S_SCH, S_SFL, S_WRD, S_WWR, S_DONE
	} state_t;

	state_t            state_q;
	logic              fit_q, clr_cmd_q, val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IW-1:0]     off_q, end_q, pos_q;
	logic [1:0]        status_q;
	logic [31:0]       astart_q, base_q;
	logic [CNT_W-1:0]  bcnt_q;
	logic [AW-1:0]     wix_q;
	logic [WW-1:0]     word_q;
	logic [IW-1:0]     c_off_q, c_len_q, b_off_q, b_len_q, lg_q, tot_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [WW-1:0]     mem [DEPTH];
	logic [WW-1:0]     rd_q;
	logic              mem_we;
	logic [WW-1:0]     mem_wd, mask;

	logic [IW-1:0]     n;
	logic [IW-1:0]     c_off_n, c_len_n, b_off_n, b_len_n, lg_n, tot_n;
	logic [IW-1:0]     pos_nx;
	logic [32:0]       diff, run_end;
	logic              out_range;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign n = (32'(bcnt_q) > 32'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : IW'(bcnt_q);
	assign pos_nx = pos_q + IW'(CH);

	assign diff      = {1'b0, in_data.first_blk} - {1'b0, base_q};
	assign run_end   = diff + 33'(in_data.count);
	assign out_range = diff[32] || (run_end > 33'(n));

	// run tracking over one 8-bit slice; flush treats everything as busy
	always_comb begin
		logic [IW-1:0] g;
		logic          busy;
		c_off_n = c_off_q;
		c_len_n = c_len_q;
		b_off_n = b_off_q;
		b_len_n = b_len_q;
		lg_n    = lg_q;
		tot_n   = tot_q;
		for (int i = 0; i < CH; i++) begin
			g    = pos_q + IW'(i);
			busy = (state_q == S_SFL) || (g >= n) || word_q[i];
			if (!busy) begin
				if (c_len_n == '0)
					c_off_n = g;
				c_len_n = c_len_n + 1'b1;
				tot_n   = tot_n + 1'b1;
			end else begin
				if (32'(c_len_n) >= 32'(cnt_q) && c_len_n != '0 &&
				    (b_len_n == '0 || c_len_n < b_len_n)) begin
					b_len_n = c_len_n;
					b_off_n = c_off_n;
				end
				if (c_len_n > lg_n)
					lg_n = c_len_n;
				c_len_n = '0;
			end
		end
	end

	always_comb begin
		logic [IW-1:0] g;
		for (int j = 0; j < WW; j++) begin
			g       = IW'({wix_q, LWW'(j)});
			mask[j] = (g >= off_q) && (g < end_q);
		end
	end

	assign mem_we = (state_q == S_CLR) || (state_q == S_WWR);
	assign mem_wd = (state_q == S_CLR) ? '0 : (val_q ? (rd_q | mask) : (rd_q & ~mask));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wix_q] <= mem_wd;
		rd_q <= mem[wix_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cmd_q   <= 1'b0;
			fit_q       <= 1'b0;
			wix_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			base_q      <= '0;
			bcnt_q      <= BLOCK_COUNT_RST;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_BASE)
					base_q <= cfg_data;
				else
					bcnt_q <= cfg_data[CNT_W-1:0];
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_CLR: begin
					wix_q <= wix_q + 1'b1;
					if (wix_q == AW'(DEPTH - 1)) begin
						wix_q <= '0;
						pos_q <= '0;
						if (clr_cmd_q) begin
							clr_cmd_q <= 1'b0;
							state_q   <= S_SRD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cnt_q    <= in_data.count;
						status_q <= ST_OK;
						astart_q <= '0;
						fit_q    <= 1'b0;
						wix_q    <= '0;
						pos_q    <= '0;
						state_q  <= S_SRD;
						case (in_data.cmd)
							CMD_ALLOC: begin
								if (in_data.count == '0)
									status_q <= ST_INVALID;
								else
									fit_q <= 1'b1;
							end
							CMD_FREE, CMD_MARK: begin
								if (in_data.count != '0) begin
									if (out_range) begin
										status_q <= ST_RANGE;
									end else begin
										off_q   <= IW'(diff);
										end_q   <= IW'(run_end);
										wix_q   <= AW'(diff[31:0] >> LWW);
										val_q   <= (in_data.cmd == CMD_MARK);
										state_q <= S_WRD;
									end
								end
							end
							default: begin
								clr_cmd_q <= 1'b1;
								state_q   <= S_CLR;
							end
						endcase
					end
				end
				S_SRD: state_q <= S_SLD;
				S_SLD: begin
					word_q <= rd_q;
					if (pos_q == '0) begin
						c_off_q <= '0;
						c_len_q <= '0;
						b_off_q <= '0;
						b_len_q <= '0;
						lg_q    <= '0;
						tot_q   <= '0;
					end
					state_q <= S_SCH;
				end
				S_SCH: begin
					c_off_q <= c_off_n;
					c_len_q <= c_len_n;
					b_off_q <= b_off_n;
					b_len_q <= b_len_n;
					lg_q    <= lg_n;
					tot_q   <= tot_n;
					word_q  <= word_q >> CH;
					pos_q   <= pos_nx;
					if ((pos_nx & IW'(WW - 1)) == '0) begin
						if (pos_nx >= n || wix_q == AW'(DEPTH - 1)) begin
							state_q <= S_SFL;
						end else begin
							wix_q   <= wix_q + 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_SFL: begin
					c_len_q <= c_len_n;
					lg_q    <= lg_n;
					tot_q   <= tot_n;
					if (fit_q) begin
						fit_q <= 1'b0;
						if (b_len_n == '0) begin
							status_q <= ST_NOSPACE;
							wix_q    <= '0;
							pos_q    <= '0;
							state_q  <= S_SRD;
						end else begin
							off_q    <= b_off_n;
							end_q    <= b_off_n + IW'(cnt_q);
							wix_q    <= AW'(b_off_n >> LWW);
							val_q    <= 1'b1;
							astart_q <= base_q + 32'(b_off_n);
							state_q  <= S_WRD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: begin
					if (IW'({wix_q, {LWW{1'b1}}}) >= end_q - 1'b1) begin
						wix_q   <= '0;
						pos_q   <= '0;
						state_q <= S_SRD;
					end else begin
						wix_q   <= wix_q + 1'b1;
						state_q <= S_WRD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.status      <= status_q;
						out_q.alloc_start <= astart_q;
						out_q.largest_run <= CNT_W'(lg_q);
						out_q.free_blocks <= CNT_W'(tot_q);
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted command did not start");

	a_largest_le_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.largest_run <= out_q.free_blocks)
		else $error("largest run exceeds free count");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !in_ready && !(state_q == S_SCH || state_q == S_SFL))
		else $error("map write outside write pass");

	a_alloc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.alloc_start == '0)
		else $error("alloc start set on failed command");

endmodule

### tb/sv/best_fit_block_bitmap_allocator_tb.sv
module best_fit_block_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfba_pkg::*;

	localparam int NBLK = MAX_BLOCKS_DEF;

	// tracks the bitmap and the queue of predicted results
	class alloc_scoreboard;
		bit          used_map [NBLK];
		logic [31:0] base_blk;
		logic [10:0] blk_cnt;
		rsp_t        pending [$];
		int          errors;

		function new();
			errors = 0;
			base_blk = '0;
			blk_cnt = BLOCK_COUNT_RST;
			foreach (used_map[i]) used_map[i] = 1'b0;
		endfunction

		function int region_len();
			return (blk_cnt > NBLK) ? NBLK : int'(blk_cnt);
		endfunction

		function void note_cfg(logic idx, logic [31:0] val);
			if (idx == REG_BASE)
				base_blk = val;
			else
				blk_cnt = val[10:0];
		endfunction

		function void note_request(req_t rq);
			rsp_t        r;
			int          n, best_off, fit_len, cur_off, cur_len, run, total;
			longint      off;
			bit          busy;
			n = region_len();
			r = '0;
			r.status = ST_OK;
			case (rq.cmd)
				CMD_ALLOC: begin
					if (rq.count == 0) begin
						r.status = ST_INVALID;
					end else begin
						best_off = 0; fit_len = 0; cur_off = 0; cur_len = 0;
						for (int i = 0; i <= n; i++) begin
							busy = (i == n) || used_map[i];
							if (!busy) begin
								if (cur_len == 0) cur_off = i;
								cur_len++;
							end else begin
								if (cur_len >= rq.count && (fit_len == 0 || cur_len < fit_len)) begin
									fit_len = cur_len;
									best_off = cur_off;
								end
								cur_len = 0;
							end
						end
						if (fit_len == 0) begin
							r.status = ST_NOSPACE;
						end else begin
							for (int i = 0; i < rq.count; i++)
								if (best_off + i < NBLK) used_map[best_off + i] = 1'b1;
							r.alloc_start = base_blk + 32'(best_off);
						end
					end
				end
				CMD_FREE, CMD_MARK: begin
					if (rq.count != 0) begin
						off = longint'(rq.first_blk) - longint'(base_blk);
						if (rq.first_blk < base_blk || off + rq.count > n) begin
							r.status = ST_RANGE;
						end else begin
							for (int i = 0; i < rq.count; i++)
								used_map[off + i] = (rq.cmd == CMD_MARK);
						end
					end
				end
				default: foreach (used_map[i]) used_map[i] = 1'b0;
			endcase
			run = 0; total = 0; fit_len = 0;
			for (int i = 0; i < n; i++) begin
				if (used_map[i]) begin
					run = 0;
				end else begin
					run++;
					total++;
					if (run > fit_len) fit_len = run;
				end
			end
			r.largest_run = 11'(fit_len);
			r.free_blocks = 11'(total);
			pending.push_back(r);
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
				errors++;
			end
			if (got.alloc_start !== exp_r.alloc_start) begin
				$display("%0t: alloc_start expected %0h actual %0h", $time,
					exp_r.alloc_start, got.alloc_start);
				errors++;
			end
			if (got.largest_run !== exp_r.largest_run) begin
				$display("%0t: largest_run expected %0d actual %0d", $time,
					exp_r.largest_run, got.largest_run);
				errors++;
			end
			if (got.free_blocks !== exp_r.free_blocks) begin
				$display("%0t: free_blocks expected %0d actual %0d", $time,
					exp_r.free_blocks, got.free_blocks);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	req_t        in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_BASE;
	logic [31:0] cfg_data = '0;

	alloc_scoreboard sb = new();
	bit stall_long = 1'b0;
	bit no_gaps = 1'b0;
	int sent = 0;

	always #5 clk = ~clk;

	best_fit_block_bitmap_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	task automatic send_cmd(req_t rq);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		repeat (gap) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(rq);
		sent++;
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_cfg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic req_t mk(logic [1:0] c, logic [31:0] s, logic [10:0] n);
		req_t r;
		r.cmd = c;
		r.first_blk = s;
		r.count = n;
		return r;
	endfunction

	// mostly commands that land inside the region with small counts
	function automatic req_t rand_cmd();
		int          n;
		logic [1:0]  c;
		logic [31:0] s;
		logic [10:0] k;
		n = sb.region_len();
		c = 2'($urandom_range(0, 99) < 45 ? CMD_ALLOC :
			$urandom_range(0, 99) < 55 ? CMD_FREE :
			$urandom_range(0, 99) < 95 ? CMD_MARK : CMD_CLEAR);
		case ($urandom_range(0, 9))
			0: k = 11'($urandom_range(0, 2047));
			1: k = 11'($urandom_range(0, 1024));
			2: k = '0;
			default: k = 11'($urandom_range(1, 64));
		endcase
		if ($urandom_range(0, 9) == 0 || n == 0)
			s = $urandom();
		else
			s = sb.base_blk + 32'($urandom_range(0, n - 1));
		return mk(c, s, k);
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_data);
	end

	// result side: random holds, plus one long hold-off on request
	initial begin
		int hold;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_long) begin
				out_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				stall_long = 1'b0;
			end
			hold = no_gaps ? 0 : $urandom_range(0, 13);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#60ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [31:0] bases [4];
		logic [10:0] counts [5];
		bases = '{32'h0, 32'hFFFF_FC00, 32'h1234_5678, 32'hFFFF_FFFF};
		counts = '{11'd1024, 11'd0, 11'd2047, 11'd37, 11'd200};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes and every command
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd0));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd1025));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd2047));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd10));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd5));
		send_cmd(mk(CMD_FREE, 32'd3, 11'd4));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd2));
		send_cmd(mk(CMD_FREE, 32'hFFFF_FFFF, 11'd0));
		send_cmd(mk(CMD_MARK, 32'd1020, 11'd5));
		send_cmd(mk(CMD_MARK, 32'd1023, 11'd1));
		send_cmd(mk(CMD_FREE, 32'hFFFF_FFFF, 11'd2047));
		send_cmd(mk(CMD_MARK, 32'd0, 11'd1024));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd1));
		send_cmd(mk(CMD_FREE, 32'd100, 11'd1));
		send_cmd(mk(CMD_FREE, 32'd500, 11'd3));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd1));
		send_cmd(mk(CMD_CLEAR, 32'hFFFF_FFFF, 11'd2047));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd1024));
		send_cmd(mk(CMD_CLEAR, 32'h0, 11'd0));
		drain();

		write_reg(REG_BASE, 32'hFFFF_FFF0);
		write_reg(REG_COUNT, 32'd2047);
		send_cmd(mk(CMD_MARK, 32'hFFFF_FFEF, 11'd1));
		send_cmd(mk(CMD_MARK, 32'hFFFF_FFF0, 11'd1));
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd100));
		send_cmd(mk(CMD_FREE, 32'hFFFF_FFF0, 11'd1024));
		drain();
		write_reg(REG_COUNT, 32'd0);
		send_cmd(mk(CMD_ALLOC, 32'h0, 11'd1));
		send_cmd(mk(CMD_MARK, 32'hFFFF_FFF0, 11'd1));
		drain();

		// random phases over several region settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_BASE, ph < 4 ? bases[ph] : $urandom());
			write_reg(REG_COUNT, 32'(ph < 5 ? counts[ph] : 11'($urandom_range(1, 1100))));
			no_gaps = (ph == 3);
			if (ph == 2) stall_long = 1'b1;
			for (int i = 0; i < 170; i++) begin
				send_cmd(rand_cmd());
				// let the queue empty before carrying on
				if (ph == 6 && i == 80)
					while (sb.pending.size() != 0) @(negedge clk);
			end
			drain();
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

### files.f
rtl/bfba_pkg.sv
rtl/best_fit_block_bitmap_allocator.sv
tb/sv/best_fit_block_bitmap_allocator_tb.sv
